[hdl/rpa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rpa_pkg;
    localparam int ROT_WIDTH   = 16;
    localparam int ALIGN_WIDTH = 48;
    localparam int CFG_IDX_WIDTH = 3;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_ALIGN_ROW0 = 3'd0,
        REG_ALIGN_ROW1 = 3'd1,
        REG_ALIGN_ROW2 = 3'd2,
        REG_OFFSET_X   = 3'd3,
        REG_OFFSET_Y   = 3'd4,
        REG_OFFSET_Z   = 3'd5
    } cfg_reg_t;

    typedef logic signed [ROT_WIDTH-1:0] rot_t;
    typedef rot_t [2:0][2:0] mat_t;
endpackage
`default_nettype wire

[hdl/rpa_dot3.sv]
`timescale 1ns / 1ps
`default_nettype none
// Registered three-term dot product, optional negate, then round to nearest
// (ties up) by FRAC_BITS and saturate to OUT_WIDTH. Two register stages.
module rpa_dot3 #(
    parameter int A_WIDTH   = 16,
    parameter int B_WIDTH   = 24,
    parameter int OUT_WIDTH = 24,
    parameter int FRAC_BITS = 14,
    parameter bit NEGATE    = 1'b0
) (
    input  wire                          aclk,
    input  wire                          en0,
    input  wire                          en1,
    input  wire signed [A_WIDTH-1:0]     a0,
    input  wire signed [A_WIDTH-1:0]     a1,
    input  wire signed [A_WIDTH-1:0]     a2,
    input  wire signed [B_WIDTH-1:0]     b0,
    input  wire signed [B_WIDTH-1:0]     b1,
    input  wire signed [B_WIDTH-1:0]     b2,
    output logic signed [OUT_WIDTH-1:0]  y
);
    localparam int PW = A_WIDTH + B_WIDTH;
    localparam int SW = PW + 3;
    localparam int RW = SW - FRAC_BITS;
    // output range limits, widened to the rounded sum
    localparam logic signed [RW-1:0] SAT_HI = RW'({(OUT_WIDTH-1){1'b1}});
    localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [SW-1:0] sum;
    logic signed [RW-1:0] rnd;
    logic signed [OUT_WIDTH-1:0] sat_next;

    always_ff @(posedge aclk) begin
        if (en0) begin
            p0_reg <= a0 * b0;
            p1_reg <= a1 * b1;
            p2_reg <= a2 * b2;
        end
    end

    always_comb begin
        sum = SW'(p0_reg) + SW'(p1_reg) + SW'(p2_reg);
        if (NEGATE) sum = -sum;
        sum = sum + (SW'(1) <<< (FRAC_BITS - 1));
        rnd = RW'(sum >>> FRAC_BITS);
        if (rnd > SAT_HI)
            sat_next = SAT_HI[OUT_WIDTH-1:0];
        else if (rnd < SAT_LO)
            sat_next = SAT_LO[OUT_WIDTH-1:0];
        else
            sat_next = OUT_WIDTH'(rnd);
    end

    always_ff @(posedge aclk) begin
        if (en1) y <= sat_next;
    end
endmodule
`default_nettype wire

[hdl/rigid_pose_alignment_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel | Ports             | Word
// input   | s_valid/s_ready   | rotation R (9 x Q1.14), translation t (3 x Q7.16)
// result  | m_valid/m_ready   | aligned rotation and translation, same formats
// config  | cfg_valid/ready   | cfg_index (3 b), cfg_data (48 b)
//
// One word per cycle while the result is not stalled, through a chain of three
// dot-product units of two stages each: twc, then d = twc - mu in one stage,
// A*d, then -R'*atwc; R' = R*A^T runs alongside.
// aresetn (sync, low) clears the valid bits and loads identity / zero config.
// A stall at m_ready freezes every stage at once; nothing is lost or doubled.
module rigid_pose_alignment_top #(
    parameter int ROT_FRAC_BITS = 14,
    parameter int TRANS_WIDTH   = 24
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire signed [15:0]             s_in_r00, s_in_r01, s_in_r02,
    input  wire signed [15:0]             s_in_r10, s_in_r11, s_in_r12,
    input  wire signed [15:0]             s_in_r20, s_in_r21, s_in_r22,
    input  wire signed [TRANS_WIDTH-1:0]  s_in_tx, s_in_ty, s_in_tz,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic signed [15:0]            m_out_r00, m_out_r01, m_out_r02,
    output logic signed [15:0]            m_out_r10, m_out_r11, m_out_r12,
    output logic signed [15:0]            m_out_r20, m_out_r21, m_out_r22,
    output logic signed [TRANS_WIDTH-1:0] m_out_tx, m_out_ty, m_out_tz,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire [rpa_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire [rpa_pkg::ALIGN_WIDTH-1:0]   cfg_data
);
    import rpa_pkg::*;

    localparam int TW = TRANS_WIDTH;
    localparam int DEPTH = 7;

    // config
    mat_t a_reg;
    logic signed [TW-1:0] mu_reg [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++)
                    a_reg[i][j] <= (i == j) ? rot_t'(1 << ROT_FRAC_BITS) : '0;
                mu_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_ALIGN_ROW0: a_reg[0] <= cfg_data;
                REG_ALIGN_ROW1: a_reg[1] <= cfg_data;
                REG_ALIGN_ROW2: a_reg[2] <= cfg_data;
                REG_OFFSET_X:   mu_reg[0] <= cfg_data[TW-1:0];
                REG_OFFSET_Y:   mu_reg[1] <= cfg_data[TW-1:0];
                REG_OFFSET_Z:   mu_reg[2] <= cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control: global enable
    logic [DEPTH-1:0] vld_reg;
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
    end

    mat_t r_in;
    assign r_in = '{'{s_in_r22, s_in_r21, s_in_r20},
                    '{s_in_r12, s_in_r11, s_in_r10},
                    '{s_in_r02, s_in_r01, s_in_r00}};

    // stages 1-2: twc = -R^T t, and R' = R A^T
    logic signed [TW-1:0] twc [3];
    mat_t rout_s2;
    for (genvar i = 0; i < 3; i++) begin : g_twc
        rpa_dot3 #(.A_WIDTH(16), .B_WIDTH(TW), .OUT_WIDTH(TW),
                   .FRAC_BITS(ROT_FRAC_BITS), .NEGATE(1'b1)) u_twc (
            .aclk(aclk), .en0(adv), .en1(adv),
            .a0(r_in[0][i]), .a1(r_in[1][i]), .a2(r_in[2][i]),
            .b0(s_in_tx), .b1(s_in_ty), .b2(s_in_tz), .y(twc[i]));
        for (genvar j = 0; j < 3; j++) begin : g_rout
            rpa_dot3 #(.A_WIDTH(16), .B_WIDTH(16), .OUT_WIDTH(16),
                       .FRAC_BITS(ROT_FRAC_BITS), .NEGATE(1'b0)) u_r (
                .aclk(aclk), .en0(adv), .en1(adv),
                .a0(a_reg[j][0]), .a1(a_reg[j][1]), .a2(a_reg[j][2]),
                .b0(r_in[i][0]), .b1(r_in[i][1]), .b2(r_in[i][2]),
                .y(rout_s2[i][j]));
        end
    end

    // stage 3: d = sat(twc - mu)
    logic signed [TW-1:0] d_reg [3];
    mat_t rout_s3_reg, rout_s4_reg, rout_s5_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [TW:0] df;
                df = {twc[k][TW-1], twc[k]} - {mu_reg[k][TW-1], mu_reg[k]};
                if (df[TW] != df[TW-1])
                    d_reg[k] <= df[TW] ? {1'b1, {(TW-1){1'b0}}}
                                       : {1'b0, {(TW-1){1'b1}}};
                else
                    d_reg[k] <= df[TW-1:0];
            end
            rout_s3_reg <= rout_s2;
            rout_s4_reg <= rout_s3_reg;
            rout_s5_reg <= rout_s4_reg;
        end
    end

    // stages 4-5: atwc = A d
    logic signed [TW-1:0] atwc [3];
    for (genvar i = 0; i < 3; i++) begin : g_atwc
        rpa_dot3 #(.A_WIDTH(16), .B_WIDTH(TW), .OUT_WIDTH(TW),
                   .FRAC_BITS(ROT_FRAC_BITS), .NEGATE(1'b0)) u_a (
            .aclk(aclk), .en0(adv), .en1(adv),
            .a0(a_reg[i][0]), .a1(a_reg[i][1]), .a2(a_reg[i][2]),
            .b0(d_reg[0]), .b1(d_reg[1]), .b2(d_reg[2]), .y(atwc[i]));
    end

    // stages 6-7: out_t = -R' atwc
    mat_t rout_s6_reg, rout_s7_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            rout_s6_reg <= rout_s5_reg;
            rout_s7_reg <= rout_s6_reg;
        end
    end
    logic signed [TW-1:0] tout [3];
    for (genvar i = 0; i < 3; i++) begin : g_tout
        rpa_dot3 #(.A_WIDTH(16), .B_WIDTH(TW), .OUT_WIDTH(TW),
                   .FRAC_BITS(ROT_FRAC_BITS), .NEGATE(1'b1)) u_t (
            .aclk(aclk), .en0(adv), .en1(adv),
            .a0(rout_s5_reg[i][0]), .a1(rout_s5_reg[i][1]), .a2(rout_s5_reg[i][2]),
            .b0(atwc[0]), .b1(atwc[1]), .b2(atwc[2]), .y(tout[i]));
    end

    assign m_out_r00 = rout_s7_reg[0][0];
    assign m_out_r01 = rout_s7_reg[0][1];
    assign m_out_r02 = rout_s7_reg[0][2];
    assign m_out_r10 = rout_s7_reg[1][0];
    assign m_out_r11 = rout_s7_reg[1][1];
    assign m_out_r12 = rout_s7_reg[1][2];
    assign m_out_r20 = rout_s7_reg[2][0];
    assign m_out_r21 = rout_s7_reg[2][1];
    assign m_out_r22 = rout_s7_reg[2][2];
    assign m_out_tx  = tout[0];
    assign m_out_ty  = tout[1];
    assign m_out_tz  = tout[2];

    // a stalled result word holds still
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_tx) && $stable(m_out_r00))
        else $error("result word changed under stall");
    // input taken only while output can move
    a_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready mismatch");
    // reset empties the pipeline
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
endmodule
`default_nettype wire

[tb/rigid_pose_alignment_top_tb.sv]
`timescale 1ns / 1ps
module rigid_pose_alignment_top_tb;
    import rpa_pkg::*;

    localparam int TW         = 24;
    localparam int FRAC       = 14;
    localparam int ONE        = 1 << FRAC;
    localparam int LIMIT      = 400000;
    localparam int DRAIN_WAIT = 12;     // longer than the pipeline depth
    localparam int PHASE_LEN  = 155;
    // indexes past the register list; writes there must be dropped
    localparam logic [CFG_IDX_WIDTH-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] IDX_SPARE_HI = 3'd7;

    typedef struct {
        logic signed [15:0]   r[3][3];
        logic signed [TW-1:0] t[3];
    } pose_t;

    // pose scoreboard: predicts the aligned pose and holds it until it comes out
    class pose_scoreboard;
        logic [ALIGN_WIDTH-1:0] align_row[3];
        logic signed [TW-1:0]   offset[3];
        pose_t                  aligned_q[$];
        int                     errors;

        function new();
            align_row[0] = 48'd1 << FRAC;
            align_row[1] = 48'd1 << (FRAC + 16);
            align_row[2] = 48'd1 << (FRAC + 32);
            foreach (offset[i]) offset[i] = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [ALIGN_WIDTH-1:0] data);
            case (idx)
                REG_ALIGN_ROW0: align_row[0] = data;
                REG_ALIGN_ROW1: align_row[1] = data;
                REG_ALIGN_ROW2: align_row[2] = data;
                REG_OFFSET_X:   offset[0] = data[TW-1:0];
                REG_OFFSET_Y:   offset[1] = data[TW-1:0];
                REG_OFFSET_Z:   offset[2] = data[TW-1:0];
                default: ;
            endcase
        endfunction

        function longint rnd(longint x);
            return (x + (longint'(1) << (FRAC - 1))) >>> FRAC;
        endfunction

        function longint sat(longint x, int w);
            longint hi;
            hi = (longint'(1) << (w - 1)) - 1;
            if (x > hi) return hi;
            if (x < -hi - 1) return -hi - 1;
            return x;
        endfunction

        function void note_pose(pose_t p);
            longint r[3][3], a[3][3], t[3], twc[3], d[3], atwc[3], orr[3][3], acc;
            pose_t q;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r[i][j] = p.r[i][j];
                    a[i][j] = $signed(align_row[i][16*j +: 16]);
                end
                t[i] = p.t[i];
            end
            // camera-to-world position
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc -= r[k][i] * t[k];
                twc[i] = sat(rnd(acc), TW);
            end
            // R' = R * A^T
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    acc = 0;
                    for (int k = 0; k < 3; k++) acc += a[j][k] * r[i][k];
                    orr[i][j] = sat(rnd(acc), 16);
                    q.r[i][j] = orr[i][j][15:0];
                end
            for (int k = 0; k < 3; k++) d[k] = sat(twc[k] - longint'(offset[k]), TW);
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += a[i][k] * d[k];
                atwc[i] = sat(rnd(acc), TW);
            end
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc -= orr[i][k] * atwc[k];
                q.t[i] = TW'(sat(rnd(acc), TW));
            end
            aligned_q.push_back(q);
        endfunction

        function void check_pose(pose_t got);
            pose_t want;
            if (aligned_q.size() == 0) begin
                $display("%0t: result word with nothing expected", $time);
                errors++;
                return;
            end
            want = aligned_q.pop_front();
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++)
                    if (got.r[i][j] !== want.r[i][j]) begin
                        $display("%0t: out_r%0d%0d expected %0d got %0d",
                                 $time, i, j, want.r[i][j], got.r[i][j]);
                        errors++;
                    end
                if (got.t[i] !== want.t[i]) begin
                    $display("%0t: out_t[%0d] expected %0d got %0d",
                             $time, i, want.t[i], got.t[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, cfg_valid, cfg_ready;
    logic signed [15:0]   in_r[3][3], out_r[3][3];
    logic signed [TW-1:0] in_t[3], out_t[3];
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [ALIGN_WIDTH-1:0]   cfg_data;

    pose_scoreboard sb = new();
    int cycles = 0;

    rigid_pose_alignment_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_r00(in_r[0][0]), .s_in_r01(in_r[0][1]), .s_in_r02(in_r[0][2]),
        .s_in_r10(in_r[1][0]), .s_in_r11(in_r[1][1]), .s_in_r12(in_r[1][2]),
        .s_in_r20(in_r[2][0]), .s_in_r21(in_r[2][1]), .s_in_r22(in_r[2][2]),
        .s_in_tx(in_t[0]), .s_in_ty(in_t[1]), .s_in_tz(in_t[2]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_r00(out_r[0][0]), .m_out_r01(out_r[0][1]), .m_out_r02(out_r[0][2]),
        .m_out_r10(out_r[1][0]), .m_out_r11(out_r[1][1]), .m_out_r12(out_r[1][2]),
        .m_out_r20(out_r[2][0]), .m_out_r21(out_r[2][1]), .m_out_r22(out_r[2][2]),
        .m_out_tx(out_t[0]), .m_out_ty(out_t[1]), .m_out_tz(out_t[2]),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** rigid_pose_alignment_top: FAILED **");
            $finish;
        end
    end

    // result monitor: sampled at the rising edge, before the block updates
    always @(posedge aclk) begin
        pose_t got;
        if (aresetn && m_valid && m_ready) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) got.r[i][j] = out_r[i][j];
                got.t[i] = out_t[i];
            end
            sb.check_pose(got);
        end
    end

    // receiver back-pressure: the mode is picked in turn from the cycle counter
    // (always ready, coin flip, mostly stalled, or periodic)
    always @(negedge aclk) begin
        case ((cycles >> 7) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= (cycles % 5) < 3;
        endcase
    end

    task automatic send_pose(pose_t p);
        @(negedge aclk);
        s_valid <= 1'b1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) in_r[i][j] <= p.r[i][j];
            in_t[i] <= p.t[i];
        end
        do @(posedge aclk); while (!s_ready);
        sb.note_pose(p);
    endtask

    // lower valid and wait for the pipeline to empty
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.aligned_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_WIDTH-1:0] idx, logic [ALIGN_WIDTH-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_entry();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(ONE);
            3: return -16'(ONE);
            default: return 16'($urandom);
        endcase
    endfunction

    // signed permutation matrix scaled by s, with a little noise
    function automatic void perm_mat(output logic signed [15:0] m[3][3], input int s, int noise);
        int c[3];
        c[0] = $urandom_range(0, 2);
        c[1] = (c[0] + 1 + $urandom_range(0, 1)) % 3;
        c[2] = 3 - c[0] - c[1];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = (j == c[i]) ? 16'($urandom_range(0, 1) ? s : -s) : 16'sd0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] += 16'($signed($urandom_range(0, 2 * noise)) - noise);
    endfunction

    function automatic pose_t rand_pose();
        pose_t p;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 6) perm_mat(p.r, ONE, kind < 3 ? 0 : 64);
        else if (kind < 8) foreach (p.r[i, j]) p.r[i][j] = 16'($urandom);
        else foreach (p.r[i, j]) p.r[i][j] = rand_entry();
        for (int i = 0; i < 3; i++)
            case ($urandom_range(0, 3))
                0: p.t[i] = TW'($urandom);
                1: p.t[i] = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
                default: p.t[i] = TW'($signed(24'($urandom_range(0, 1 << 22))) - (1 << 21));
            endcase
        return p;
    endfunction

    function automatic logic [ALIGN_WIDTH-1:0] pack_row(logic signed [15:0] m[3][3], int i);
        return {m[i][2], m[i][1], m[i][0]};
    endfunction

    // pushes a configuration setting; row data comes from m, offsets as given
    task automatic load_setting(logic signed [15:0] m[3][3], logic [ALIGN_WIDTH-1:0] ox,
                                logic [ALIGN_WIDTH-1:0] oy, logic [ALIGN_WIDTH-1:0] oz);
        write_cfg(REG_ALIGN_ROW0, pack_row(m, 0));
        write_cfg(REG_ALIGN_ROW1, pack_row(m, 1));
        write_cfg(REG_ALIGN_ROW2, pack_row(m, 2));
        write_cfg(REG_OFFSET_X, ox);
        write_cfg(REG_OFFSET_Y, oy);
        write_cfg(REG_OFFSET_Z, oz);
    endtask

    // random items in bursts with random gaps
    task automatic random_phase(int n);
        int burst;
        burst = 0;
        for (int k = 0; k < n; k++) begin
            if (burst == 0) begin
                int gap;
                burst = $urandom_range(1, 40);
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    @(negedge aclk);
                    s_valid <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
            end
            burst--;
            send_pose(rand_pose());
        end
    endtask

    initial begin
        pose_t p;
        logic signed [15:0] m[3][3];

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        foreach (in_r[i, j]) in_r[i][j] = '0;
        foreach (in_t[i]) in_t[i] = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed words under the reset alignment (identity, zero offset)
        foreach (p.r[i, j]) p.r[i][j] = 0;
        foreach (p.t[i]) p.t[i] = 0;
        send_pose(p);
        foreach (p.r[i, j]) p.r[i][j] = 16'sh7FFF;
        foreach (p.t[i]) p.t[i] = 24'sh7FFFFF;
        send_pose(p);                           // translation saturates
        foreach (p.r[i, j]) p.r[i][j] = 16'sh8000;
        foreach (p.t[i]) p.t[i] = 24'sh800000;
        send_pose(p);
        foreach (p.t[i]) p.t[i] = 24'sh7FFFFF;
        send_pose(p);
        foreach (p.r[i, j]) p.r[i][j] = (i == j) ? ONE : 0;
        foreach (p.t[i]) p.t[i] = 24'sh800000;  // negation overflows the range
        send_pose(p);
        foreach (p.t[i]) p.t[i] = 24'sh7FFFFF;
        send_pose(p);
        // rounding ties: products landing exactly on half an LSB
        foreach (p.r[i, j]) p.r[i][j] = (i == j) ? 1 : 0;
        p.t[0] = 8192; p.t[1] = -8192; p.t[2] = 24576;
        send_pose(p);
        foreach (p.r[i, j]) p.r[i][j] = (i == j) ? -16'sd1 : 16'sd0;
        send_pose(p);
        // non-orthonormal shapes
        foreach (p.r[i, j]) p.r[i][j] = (i + j) % 2 ? 16'sh7FFF : 16'sh8000;
        p.t[0] = 24'sh7FFFFF; p.t[1] = 24'sh800000; p.t[2] = 24'sh7FFFFF;
        send_pose(p);
        foreach (p.r[i, j]) p.r[i][j] = 16'sh5555 ^ 16'(i * 3 + j);
        foreach (p.t[i]) p.t[i] = 24'shAAAAAA;
        send_pose(p);
        for (int k = 0; k < 10; k++) begin
            perm_mat(p.r, ONE, 0);
            foreach (p.t[i]) p.t[i] = TW'($urandom);
            send_pose(p);
        end
        random_phase(PHASE_LEN);
        drain();                                 // sender holds off until all results are in

        // explicit identity, random offsets
        foreach (m[i, j]) m[i][j] = (i == j) ? ONE : 0;
        load_setting(m, 48'($urandom), 48'($urandom), 48'($urandom));
        random_phase(PHASE_LEN);
        drain();

        // signed permutation alignment
        perm_mat(m, ONE, 0);
        load_setting(m, 48'($urandom_range(0, 1 << 20)), 48'hFFFF_FFF0_0000, 48'($urandom));
        random_phase(PHASE_LEN);
        drain();

        // largest entries, largest offsets
        foreach (m[i, j]) m[i][j] = 16'sh7FFF;
        load_setting(m, 48'h7FFFFF, 48'h7FFFFF, 48'h7FFFFF);
        random_phase(PHASE_LEN);
        drain();

        // most negative entries and offsets; writes past the list are dropped
        foreach (m[i, j]) m[i][j] = 16'sh8000;
        load_setting(m, 48'h800000, 48'h800000, 48'h800000);
        write_cfg(IDX_SPARE_LO, 48'({$urandom, $urandom}));
        write_cfg(IDX_SPARE_HI, 48'({$urandom, $urandom}));
        random_phase(PHASE_LEN);
        drain();

        // fully random words, upper offset bits included
        foreach (m[i, j]) m[i][j] = 16'($urandom);
        load_setting(m, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}));
        random_phase(PHASE_LEN);
        drain();

        if (sb.errors == 0 && sb.aligned_q.size() == 0)
            $display("** rigid_pose_alignment_top: PASSED **");
        else
            $display("** rigid_pose_alignment_top: FAILED **");
        $finish;
    end
endmodule
